/* design/lc3ie_pkg.sv */
package lc3ie_pkg;

    localparam int WORD_W            = 16;
    localparam int REG_IDX_W         = 3;
    localparam int FLAG_W            = 3;
    localparam int OP_W              = 4;
    localparam int DEF_MEM_ADDR_BITS = 16;

    localparam logic [FLAG_W-1:0]    FLAG_NEG  = 3'd4;
    localparam logic [FLAG_W-1:0]    FLAG_ZERO = 3'd2;
    localparam logic [FLAG_W-1:0]    FLAG_POS  = 3'd1;
    localparam logic [REG_IDX_W-1:0] LINK_REG  = 3'd7;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 4'd0,
        OP_AND    = 4'd1,
        OP_NOT    = 4'd2,
        OP_BR     = 4'd3,
        OP_JMP    = 4'd4,
        OP_JSR    = 4'd5,
        OP_LD     = 4'd6,
        OP_LDR    = 4'd7,
        OP_LEA    = 4'd8,
        OP_ST     = 4'd9,
        OP_STI    = 4'd10,
        OP_STR    = 4'd11,
        OP_LDI    = 4'd12,
        OP_HWRITE = 4'd13,
        OP_HREAD  = 4'd14
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MEM1,
        S_MEM2
    } state_t;

    // Everything the execute logic decides for the word in flight.
    typedef struct packed {
        logic [WORD_W-1:0]    next_pc;
        logic                 reg_wr;
        logic [REG_IDX_W-1:0] wr_idx;
        logic [WORD_W-1:0]    wr_val;
        logic [FLAG_W-1:0]    flags;
        logic                 mem_wr;
        logic [WORD_W-1:0]    mem_addr;
    } exec_t;

endpackage

/* design/lc3ie_regfile.sv */
module lc3ie_regfile
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            re,
    input  logic [lc3ie_pkg::REG_IDX_W-1:0] raddr_a,
    input  logic [lc3ie_pkg::REG_IDX_W-1:0] raddr_b,
    output logic [lc3ie_pkg::WORD_W-1:0]    rdata_a,
    output logic [lc3ie_pkg::WORD_W-1:0]    rdata_b,
    input  logic                            we,
    input  logic [lc3ie_pkg::REG_IDX_W-1:0] waddr,
    input  logic [lc3ie_pkg::WORD_W-1:0]    wdata
);
    import lc3ie_pkg::*;

    localparam int DEPTH = 1 << REG_IDX_W;

    logic [WORD_W-1:0] rf_mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [WORD_W-1:0] rdata_a_reg;
    logic [WORD_W-1:0] rdata_b_reg;

    // An entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rf_mem[waddr] <= wdata;
        end
    end

    // A write in the same cycle as the read is passed straight through.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr_a))
            begin
                rdata_a_reg <= wdata;
            end
            else
            begin
                rdata_a_reg <= valid_reg[raddr_a] ? rf_mem[raddr_a] : '0;
            end
            if (we && (waddr == raddr_b))
            begin
                rdata_b_reg <= wdata;
            end
            else
            begin
                rdata_b_reg <= valid_reg[raddr_b] ? rf_mem[raddr_b] : '0;
            end
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* design/lc3ie_mem.sv */
module lc3ie_mem
#(
    parameter int MEM_ADDR_BITS = lc3ie_pkg::DEF_MEM_ADDR_BITS
)
(
    input  logic                         clk,
    input  logic                         re,
    input  logic                         we,
    input  logic [MEM_ADDR_BITS-1:0]     addr,
    input  logic [lc3ie_pkg::WORD_W-1:0] wdata,
    output logic [lc3ie_pkg::WORD_W-1:0] rdata
);
    import lc3ie_pkg::*;

    localparam int DEPTH = 1 << MEM_ADDR_BITS;

    logic [WORD_W-1:0] mem_array [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/lc3ie_alu.sv */
module lc3ie_alu
(
    input  lc3ie_pkg::op_t               op,
    input  logic [lc3ie_pkg::WORD_W-1:0] iw,
    input  logic [lc3ie_pkg::WORD_W-1:0] pc,
    input  logic [lc3ie_pkg::WORD_W-1:0] haddr,
    input  logic [lc3ie_pkg::WORD_W-1:0] ra,
    input  logic [lc3ie_pkg::WORD_W-1:0] rb,
    input  logic [lc3ie_pkg::WORD_W-1:0] mem_rdata,
    input  logic [lc3ie_pkg::FLAG_W-1:0] flags_in,
    output lc3ie_pkg::exec_t             result
);
    import lc3ie_pkg::*;

    logic [WORD_W-1:0]    imm5;
    logic [WORD_W-1:0]    off6;
    logic [WORD_W-1:0]    off9;
    logic [WORD_W-1:0]    off11;
    logic [WORD_W-1:0]    operand;
    logic [WORD_W-1:0]    pc_off9;
    logic [WORD_W-1:0]    base_off6;
    logic [REG_IDX_W-1:0] dr;
    logic                 set_flags;

    assign imm5      = {{(WORD_W-5){iw[4]}}, iw[4:0]};
    assign off6      = {{(WORD_W-6){iw[5]}}, iw[5:0]};
    assign off9      = {{(WORD_W-9){iw[8]}}, iw[8:0]};
    assign off11     = {{(WORD_W-11){iw[10]}}, iw[10:0]};
    assign operand   = iw[5] ? imm5 : rb;
    assign pc_off9   = pc + off9;
    assign base_off6 = ra + off6;
    assign dr        = iw[11:9];

    always_comb
    begin
        result          = '0;
        result.next_pc  = pc;
        result.mem_addr = pc_off9;
        set_flags       = 1'b0;
        case (op)
            OP_ADD:
            begin
                result.wr_val = ra + operand;
                result.reg_wr = 1'b1;
                result.wr_idx = dr;
                set_flags     = 1'b1;
            end
            OP_AND:
            begin
                result.wr_val = ra & operand;
                result.reg_wr = 1'b1;
                result.wr_idx = dr;
                set_flags     = 1'b1;
            end
            OP_NOT:
            begin
                result.wr_val = ~ra;
                result.reg_wr = 1'b1;
                result.wr_idx = dr;
                set_flags     = 1'b1;
            end
            OP_BR:
            begin
                if (|(dr & flags_in))
                begin
                    result.next_pc = pc_off9;
                end
            end
            OP_JMP:
            begin
                result.next_pc = ra;
            end
            OP_JSR:
            begin
                result.next_pc = iw[11] ? (pc + off11) : ra;
                result.wr_val  = pc;
                result.reg_wr  = 1'b1;
                result.wr_idx  = LINK_REG;
            end
            OP_LD, OP_LDI:
            begin
                result.wr_val = mem_rdata;
                result.reg_wr = 1'b1;
                result.wr_idx = dr;
                set_flags     = 1'b1;
            end
            OP_LDR:
            begin
                result.mem_addr = base_off6;
                result.wr_val   = mem_rdata;
                result.reg_wr   = 1'b1;
                result.wr_idx   = dr;
                set_flags       = 1'b1;
            end
            OP_LEA:
            begin
                result.wr_val = pc_off9;
                result.reg_wr = 1'b1;
                result.wr_idx = dr;
                set_flags     = 1'b1;
            end
            OP_ST, OP_STI:
            begin
                result.mem_wr = 1'b1;
            end
            OP_STR:
            begin
                result.mem_addr = base_off6;
                result.mem_wr   = 1'b1;
            end
            OP_HWRITE:
            begin
                result.mem_addr = haddr;
                result.mem_wr   = 1'b1;
            end
            OP_HREAD:
            begin
                result.mem_addr = haddr;
                result.wr_val   = mem_rdata;
            end
            default:
            begin
                result.next_pc = pc;
            end
        endcase

        if (!set_flags)
        begin
            result.flags = flags_in;
        end
        else if (result.wr_val == '0)
        begin
            result.flags = FLAG_ZERO;
        end
        else if (result.wr_val[WORD_W-1])
        begin
            result.flags = FLAG_NEG;
        end
        else
        begin
            result.flags = FLAG_POS;
        end
    end

endmodule

/* design/lc3_instruction_execute.sv */
// The result word is registered as the word finishes in its last state: S_EXEC for
// register, branch, jump and store operations, S_MEM1 for LD, LDR, STI and host read,
// and S_MEM2 for LDI. A new word is accepted only while idle or as the current word
// finishes. The indirect operations use the single port of the main memory twice.
// Reset clears the control, the condition flags and the register valid bits (all eight
// registers read zero); main memory is not cleared and needs no sweep after reset.
module lc3_instruction_execute
#(
    parameter int MEM_ADDR_BITS = lc3ie_pkg::DEF_MEM_ADDR_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [lc3ie_pkg::OP_W-1:0]      operation,
    input  logic [lc3ie_pkg::WORD_W-1:0]    instruction_word,
    input  logic [lc3ie_pkg::WORD_W-1:0]    current_pc,
    input  logic [lc3ie_pkg::WORD_W-1:0]    host_address,
    input  logic [lc3ie_pkg::WORD_W-1:0]    host_data,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lc3ie_pkg::WORD_W-1:0]    next_pc,
    output logic                            register_written,
    output logic [lc3ie_pkg::REG_IDX_W-1:0] written_index,
    output logic [lc3ie_pkg::WORD_W-1:0]    written_value,
    output logic [lc3ie_pkg::FLAG_W-1:0]    flags_out,
    output logic                            memory_written
);
    import lc3ie_pkg::*;

    // The block works on one word at a time and walks it through a short sequence:
    //   S_EXEC  register operands are out of the register file; the first memory
    //           access (load address, store, host access) is issued here.
    //   S_MEM1  the first memory word is back. LD, LDR and host read finish here;
    //           STI stores through the pointer and finishes, LDI issues its second read.
    //   S_MEM2  the LDI data word is back and the word finishes.
    // A word finishes in its last state once the output register is free. In that
    // same cycle the next input word can be accepted, so single-step operations run at one
    // word per cycle unless the receiver stalls. The register file bypasses the write
    // of the finishing word to the read of the new one, closing the only overlapping access.

    state_t               state_reg;
    state_t               state_next;
    state_t               last_state;

    op_t                  op_reg;
    logic [WORD_W-1:0]    iw_reg;
    logic [WORD_W-1:0]    pc_reg;
    logic [WORD_W-1:0]    haddr_reg;
    logic [WORD_W-1:0]    hdata_reg;
    logic [FLAG_W-1:0]    flags_reg;
    logic [FLAG_W-1:0]    flags_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WORD_W-1:0]    next_pc_reg;
    logic                 reg_written_reg;
    logic [REG_IDX_W-1:0] written_index_reg;
    logic [WORD_W-1:0]    written_value_reg;
    logic [FLAG_W-1:0]    flags_out_reg;
    logic                 mem_written_reg;

    logic                 in_accept;
    logic                 finish;
    logic                 out_free;

    logic [REG_IDX_W-1:0] rf_raddr_b;
    logic [WORD_W-1:0]    rf_rdata_a;
    logic [WORD_W-1:0]    rf_rdata_b;
    logic                 rf_we;

    logic                 mem_re;
    logic                 mem_we;
    logic [MEM_ADDR_BITS-1:0] mem_addr;
    logic [WORD_W-1:0]    mem_wdata;
    logic [WORD_W-1:0]    mem_rdata;

    exec_t                ex;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Stores name their data register in the destination field.
    always_comb
    begin
        if (op_t'(operation) inside {OP_ST, OP_STI, OP_STR})
        begin
            rf_raddr_b = instruction_word[11:9];
        end
        else
        begin
            rf_raddr_b = instruction_word[2:0];
        end
    end

    always_comb
    begin
        case (op_reg)
            OP_LDI:
            begin
                last_state = S_MEM2;
            end
            OP_LD, OP_LDR, OP_STI, OP_HREAD:
            begin
                last_state = S_MEM1;
            end
            default:
            begin
                last_state = S_EXEC;
            end
        endcase
    end

    assign finish = (state_reg != S_IDLE) && (state_reg == last_state) && out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (in_accept)
        begin
            state_next = S_EXEC;
        end
        else if (finish)
        begin
            state_next = S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_EXEC:
                begin
                    if (last_state != S_EXEC)
                    begin
                        state_next = S_MEM1;
                    end
                end
                S_MEM1:
                begin
                    if (last_state != S_MEM1)
                    begin
                        state_next = S_MEM2;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    // State outputs: input stall, memory port and register write-back.
    always_comb
    begin
        in_stall  = (state_reg != S_IDLE) && !finish;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = ex.mem_addr[MEM_ADDR_BITS-1:0];
        mem_wdata = (op_reg == OP_HWRITE) ? hdata_reg : rf_rdata_b;
        rf_we     = finish && ex.reg_wr;
        case (state_reg)
            S_EXEC:
            begin
                mem_re = (op_reg inside {OP_LD, OP_LDR, OP_LDI, OP_STI, OP_HREAD});
                mem_we = (op_reg inside {OP_ST, OP_STR, OP_HWRITE});
            end
            S_MEM1:
            begin
                // The word just read is the pointer of an indirect access.
                mem_addr = mem_rdata[MEM_ADDR_BITS-1:0];
                mem_re   = (op_reg == OP_LDI);
                mem_we   = (op_reg == OP_STI);
            end
            default:
            begin
                mem_re = 1'b0;
                mem_we = 1'b0;
            end
        endcase
    end

    assign flags_next     = finish ? ex.flags : flags_reg;
    assign out_valid_next = finish ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word capture.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= op_t'(operation);
            iw_reg    <= instruction_word;
            pc_reg    <= current_pc;
            haddr_reg <= host_address;
            hdata_reg <= host_data;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            next_pc_reg       <= ex.next_pc;
            reg_written_reg   <= ex.reg_wr;
            written_index_reg <= ex.wr_idx;
            written_value_reg <= ex.wr_val;
            flags_out_reg     <= ex.flags;
            mem_written_reg   <= ex.mem_wr;
        end
    end

    lc3ie_regfile u_regfile
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .re      (in_accept),
        .raddr_a (instruction_word[8:6]),
        .raddr_b (rf_raddr_b),
        .rdata_a (rf_rdata_a),
        .rdata_b (rf_rdata_b),
        .we      (rf_we),
        .waddr   (ex.wr_idx),
        .wdata   (ex.wr_val)
    );

    lc3ie_mem #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_mem
    (
        .clk   (clk),
        .re    (mem_re),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    lc3ie_alu u_alu
    (
        .op        (op_reg),
        .iw        (iw_reg),
        .pc        (pc_reg),
        .haddr     (haddr_reg),
        .ra        (rf_rdata_a),
        .rb        (rf_rdata_b),
        .mem_rdata (mem_rdata),
        .flags_in  (flags_reg),
        .result    (ex)
    );

    assign out_valid        = out_valid_reg;
    assign next_pc          = next_pc_reg;
    assign register_written = reg_written_reg;
    assign written_index    = written_index_reg;
    assign written_value    = written_value_reg;
    assign flags_out        = flags_out_reg;
    assign memory_written   = mem_written_reg;

endmodule

/* test/tb_lc3_instruction_execute.sv */
module tb_lc3_instruction_execute;

    import lc3ie_pkg::*;

    // Address bits of the instance; every memory address keeps only these low bits.
    localparam int          ADDR_BITS = DEF_MEM_ADDR_BITS;
    localparam logic [15:0] ADDR_MASK = 16'((1 << ADDR_BITS) - 1);

    // One retired instruction as it leaves the block.
    typedef struct packed {
        logic [WORD_W-1:0]    next_pc;
        logic                 reg_wr;
        logic [REG_IDX_W-1:0] wr_idx;
        logic [WORD_W-1:0]    wr_val;
        logic [FLAG_W-1:0]    flags;
        logic                 mem_wr;
    } retire_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                 in_valid;
    logic                 in_stall;
    op_t                  operation;
    logic [WORD_W-1:0]    instruction_word;
    logic [WORD_W-1:0]    current_pc;
    logic [WORD_W-1:0]    host_address;
    logic [WORD_W-1:0]    host_data;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [WORD_W-1:0]    next_pc;
    logic                 register_written;
    logic [REG_IDX_W-1:0] written_index;
    logic [WORD_W-1:0]    written_value;
    logic [FLAG_W-1:0]    flags_out;
    logic                 memory_written;

    // Shadow copy of the architectural state, advanced once per accepted word.
    logic [WORD_W-1:0] shadow_regs [8];
    logic [FLAG_W-1:0] shadow_flags;
    logic [WORD_W-1:0] shadow_mem [0:65535];
    bit                mem_known [0:65535];
    logic [WORD_W-1:0] known_addrs [$];

    // Results predicted for accepted words, oldest first.
    retire_t expected_retires [$];

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int errors         = 0;

    lc3_instruction_execute i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .instruction_word (instruction_word),
        .current_pc       (current_pc),
        .host_address     (host_address),
        .host_data        (host_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .next_pc          (next_pc),
        .register_written (register_written),
        .written_index    (written_index),
        .written_value    (written_value),
        .flags_out        (flags_out),
        .memory_written   (memory_written)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [15:0] sign_extend(logic [15:0] v, int bits);
        logic [15:0] upper;
        upper = 16'hFFFF << bits;
        return v[bits-1] ? (v | upper) : (v & ~upper);
    endfunction

    function automatic logic [15:0] mem_index(logic [15:0] addr);
        return addr & ADDR_MASK;
    endfunction

    function automatic logic [FLAG_W-1:0] flags_of(logic [15:0] v);
        if (v == 16'h0000)
            return FLAG_ZERO;
        return v[15] ? FLAG_NEG : FLAG_POS;
    endfunction

    function automatic logic [15:0] shadow_load(logic [15:0] addr);
        return shadow_mem[mem_index(addr)];
    endfunction

    task automatic shadow_store(logic [15:0] addr, logic [15:0] data);
        logic [15:0] k;
        k = mem_index(addr);
        shadow_mem[k] = data;
        if (!mem_known[k])
        begin
            mem_known[k] = 1'b1;
            known_addrs.push_back(k);
        end
    endtask

    // Executes one instruction on the shadow state and queues the result word it retires.
    task automatic execute_instruction(op_t op, logic [15:0] iw, logic [15:0] pc,
                                       logic [15:0] ha, logic [15:0] hd);
        retire_t     r;
        logic [2:0]  dr;
        logic [15:0] base;
        logic [15:0] operand;
        logic        set_cc;
        dr      = iw[11:9];
        base    = shadow_regs[iw[8:6]];
        operand = iw[5] ? sign_extend(iw, 5) : shadow_regs[iw[2:0]];
        set_cc  = 1'b0;
        r       = '0;
        r.next_pc = pc;
        case (op)
            OP_ADD:
            begin
                r.wr_val = base + operand;
                r.reg_wr = 1'b1; r.wr_idx = dr; set_cc = 1'b1;
            end
            OP_AND:
            begin
                r.wr_val = base & operand;
                r.reg_wr = 1'b1; r.wr_idx = dr; set_cc = 1'b1;
            end
            OP_NOT:
            begin
                r.wr_val = ~base;
                r.reg_wr = 1'b1; r.wr_idx = dr; set_cc = 1'b1;
            end
            OP_BR:
            begin
                if ((dr & shadow_flags) != 3'b000)
                    r.next_pc = pc + sign_extend(iw, 9);
            end
            OP_JMP:
                r.next_pc = base;
            OP_JSR:
            begin
                // The base register is read before the link register is written.
                r.next_pc = iw[11] ? pc + sign_extend(iw, 11) : base;
                r.wr_val  = pc;
                r.reg_wr  = 1'b1; r.wr_idx = LINK_REG;
            end
            OP_LD:
            begin
                r.wr_val = shadow_load(pc + sign_extend(iw, 9));
                r.reg_wr = 1'b1; r.wr_idx = dr; set_cc = 1'b1;
            end
            OP_LDR:
            begin
                r.wr_val = shadow_load(base + sign_extend(iw, 6));
                r.reg_wr = 1'b1; r.wr_idx = dr; set_cc = 1'b1;
            end
            OP_LEA:
            begin
                r.wr_val = pc + sign_extend(iw, 9);
                r.reg_wr = 1'b1; r.wr_idx = dr; set_cc = 1'b1;
            end
            OP_ST:
            begin
                shadow_store(pc + sign_extend(iw, 9), shadow_regs[dr]);
                r.mem_wr = 1'b1;
            end
            OP_STI:
            begin
                shadow_store(shadow_load(pc + sign_extend(iw, 9)), shadow_regs[dr]);
                r.mem_wr = 1'b1;
            end
            OP_STR:
            begin
                shadow_store(base + sign_extend(iw, 6), shadow_regs[dr]);
                r.mem_wr = 1'b1;
            end
            OP_LDI:
            begin
                r.wr_val = shadow_load(shadow_load(pc + sign_extend(iw, 9)));
                r.reg_wr = 1'b1; r.wr_idx = dr; set_cc = 1'b1;
            end
            OP_HWRITE:
            begin
                shadow_store(ha, hd);
                r.mem_wr = 1'b1;
            end
            OP_HREAD:
                r.wr_val = shadow_load(ha);
            default: ;
        endcase
        if (r.reg_wr)
            shadow_regs[r.wr_idx] = r.wr_val;
        if (set_cc)
            shadow_flags = flags_of(r.wr_val);
        r.flags = shadow_flags;
        expected_retires.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one word and returns at the rising edge that accepted it. Valid is left high,
    // so the caller must either offer the next word or park the input at the next falling
    // edge. The sender may idle first, as the current phase asks.
    task automatic send_word(op_t op, logic [15:0] iw, logic [15:0] pc,
                             logic [15:0] ha, logic [15:0] hd);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        operation        <= op;
        instruction_word <= iw;
        current_pc       <= pc;
        host_address     <= ha;
        host_data        <= hd;
        do
            @(posedge clk);
        while (in_stall);
        execute_instruction(op, iw, pc, ha, hd);
    endtask

    task automatic idle_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Memory reads of words never written are not allowed, so a host write fills such a
    // word first. This also gives the loads the store-then-load sequences they need.
    task automatic ensure_written(logic [15:0] addr, logic [15:0] data);
        if (!mem_known[mem_index(addr)])
            send_word(OP_HWRITE, 16'($urandom), 16'($urandom), addr, data);
    endtask

    task automatic send_random_word();
        op_t         op;
        logic [15:0] iw;
        logic [15:0] pc;
        logic [15:0] ha;
        logic [15:0] ptr;
        logic [15:0] seen;
        op   = op_t'($urandom_range(14));
        iw   = 16'($urandom);
        pc   = 16'($urandom);
        ha   = 16'($urandom);
        seen = 16'($urandom);
        if (known_addrs.size() != 0)
            seen = known_addrs[$urandom_range(known_addrs.size() - 1)];
        case (op)
            OP_LD, OP_LDI, OP_STI:
            begin
                // Half the time aim straight at a word that already holds data.
                if ($urandom_range(1) == 1)
                    pc = seen - sign_extend(iw, 9);
                ptr = pc + sign_extend(iw, 9);
                ensure_written(ptr, ($urandom_range(1) == 1) ? seen : 16'($urandom));
                if (op == OP_LDI)
                    ensure_written(shadow_load(ptr), 16'($urandom));
            end
            OP_LDR:
                ensure_written(shadow_regs[iw[8:6]] + sign_extend(iw, 6), 16'($urandom));
            OP_HREAD:
            begin
                if ($urandom_range(3) != 0)
                    ha = seen;
                ensure_written(ha, 16'($urandom));
            end
            default: ;
        endcase
        send_word(op, iw, pc, ha, 16'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // The receiver stalls at random, or for a counted stretch when a test asks for one.
    always @(negedge clk)
    begin
        if (hold_len > 0)
        begin
            out_stall <= 1'b1;
            hold_len = hold_len - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        retire_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_retires.size() == 0)
            begin
                errors++;
                $display("%0t: result word with nothing expected, next_pc %h", $time, next_pc);
            end
            else
            begin
                want = expected_retires.pop_front();
                compare_field("next_pc", want.next_pc, next_pc);
                compare_field("register_written", 16'(want.reg_wr), 16'(register_written));
                compare_field("written_index", 16'(want.wr_idx), 16'(written_index));
                compare_field("written_value", want.wr_val, written_value);
                compare_field("flags_out", 16'(want.flags), 16'(flags_out));
                compare_field("memory_written", 16'(want.mem_wr), 16'(memory_written));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every operation, branch with no condition bits, branch before any
    // flag is set, address wrap at both ends, indirect access, host read and JSRR on R7.
    task automatic test_directed_cases();
        send_word(OP_BR,     16'h0E05, 16'h3000, 16'h0000, 16'h0000);
        send_word(OP_LEA,    16'hE2FF, 16'h3000, 16'h0000, 16'h0000);
        send_word(OP_LEA,    16'hE500, 16'h0010, 16'h0000, 16'h0000);
        send_word(OP_BR,     16'h0900, 16'h0005, 16'h0000, 16'h0000);
        send_word(OP_BR,     16'h0401, 16'h0040, 16'h0000, 16'h0000);
        send_word(OP_BR,     16'h01FF, 16'h0040, 16'h0000, 16'h0000);
        send_word(OP_ADD,    16'h1670, 16'h0050, 16'h0000, 16'h0000);
        send_word(OP_ADD,    16'h1881, 16'h0051, 16'h0000, 16'h0000);
        send_word(OP_ADD,    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(OP_AND,    16'h5B2F, 16'h0060, 16'h0000, 16'h0000);
        // R0 is still zero here, so this leaves the zero flag set.
        send_word(OP_AND,    16'h5001, 16'h0061, 16'h0000, 16'h0000);
        send_word(OP_BR,     16'h05FF, 16'hFF80, 16'h0000, 16'h0000);
        send_word(OP_NOT,    16'h9C3F, 16'h0070, 16'h0000, 16'h0000);
        send_word(OP_HWRITE, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000);
        send_word(OP_HWRITE, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_word(OP_LD,     16'h23FF, 16'h0000, 16'h0000, 16'h0000);
        send_word(OP_LDI,    16'hA5FF, 16'h0001, 16'h0000, 16'h0000);
        send_word(OP_ST,     16'h3C00, 16'h1000, 16'h0000, 16'h0000);
        send_word(OP_STR,    16'h7C20, 16'h1001, 16'h0000, 16'h0000);
        send_word(OP_STI,    16'hB7FF, 16'h0001, 16'h0000, 16'h0000);
        send_word(OP_LDR,    16'h6620, 16'h1002, 16'h0000, 16'h0000);
        send_word(OP_HREAD,  16'h0000, 16'h1003, 16'hFFFF, 16'h0000);
        send_word(OP_JMP,    16'hC180, 16'h1004, 16'h0000, 16'h0000);
        send_word(OP_JSR,    16'h4BFF, 16'h4000, 16'h0000, 16'h0000);
        send_word(OP_JSR,    16'h4C00, 16'h0100, 16'h0000, 16'h0000);
        send_word(OP_JSR,    16'h41C0, 16'h2000, 16'h0000, 16'h0000);
        send_word(OP_NOT,    16'h0000, 16'h2001, 16'h0000, 16'h0000);
    endtask

    task automatic test_random_traffic(int count, int gap_pct, int stall_pct);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_random_word();
    endtask

    // The receiver holds off for a long stretch while words keep coming, so the block
    // fills up and has to stall its input.
    task automatic test_output_backpressure();
        idle_input();
        @(posedge clk);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_len       = 64;
        repeat (16)
            send_random_word();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        operation        = OP_ADD;
        instruction_word = '0;
        current_pc       = '0;
        host_address     = '0;
        host_data        = '0;
        foreach (shadow_regs[i])
            shadow_regs[i] = '0;
        shadow_flags = '0;

        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(170, 34, 47);
        test_output_backpressure();
        test_random_traffic(170, 47, 34);
        test_random_traffic(170, 0, 0);

        // Let the last words drain, then allow the deepest latency a few times over.
        idle_input();
        while (expected_retires.size() != 0)
            @(posedge clk);
        repeat (12)
            @(posedge clk);

        if (errors == 0)
            $display("[lc3_instruction_execute] OK");
        else
            $display("[lc3_instruction_execute] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this sequence.
    initial
    begin
        #5000000;
        $display("[lc3_instruction_execute] ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/lc3ie_pkg.sv
design/lc3ie_regfile.sv
design/lc3ie_mem.sv
design/lc3ie_alu.sv
design/lc3_instruction_execute.sv
test/tb_lc3_instruction_execute.sv
